@@ rtl/io_permission_bitmap_check_top_macros.svh @@
// ---------------------------------------------------------------------------
// io_permission_bitmap_check_top_macros
// assertion macros used by iopbc_ctrl
// ---------------------------------------------------------------------------
`ifndef IO_PERMISSION_BITMAP_CHECK_TOP_MACROS_SVH
`define IO_PERMISSION_BITMAP_CHECK_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define IOPBC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define IOPBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/iopbc_pkg.sv @@
// ---------------------------------------------------------------------------
// iopbc_pkg
// types and constants of the i/o permission bitmap check
// ---------------------------------------------------------------------------
package iopbc_pkg;

    localparam int BITMAP_BYTES = 8192;
    localparam int ADDR_W       = $clog2(BITMAP_BYTES);
    localparam int LIMIT_W      = 14;
    localparam int PORT_W       = 16;
    localparam int LEN_W        = 3;
    localparam int INDEX_W      = 13;
    localparam int BYTE_W       = 8;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 14;
    localparam int PRIV_W       = 2;
    localparam int BIT_W        = 3;
    localparam int SPAN_W       = 4;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_PROTECTED_MODE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VIRTUAL_8086      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CURRENT_PRIVILEGE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IO_PRIVILEGE      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BITMAP_LIMIT      = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1
    } state_t;

    typedef struct packed {
        logic mem_we;
        logic addr_from_in;
        logic capture;
        logic latch_byte0;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_is_check;
        logic out_ready;
    } status_t;

endpackage

@@ rtl/iopbc_req_if.sv @@
// ---------------------------------------------------------------------------
// iopbc_req_if
// request channel: bitmap loads and access checks
// ---------------------------------------------------------------------------
interface iopbc_req_if;
    import iopbc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  opcode;
    logic [PORT_W-1:0]     port;
    logic [LEN_W-1:0]      access_len;
    logic [INDEX_W-1:0]    map_index;
    logic [BYTE_W-1:0]     map_byte;

    modport source (
        output valid, opcode, port, access_len, map_index, map_byte,
        input  ready
    );
    modport sink (
        input  valid, opcode, port, access_len, map_index, map_byte,
        output ready
    );
endinterface

@@ rtl/iopbc_rsp_if.sv @@
// ---------------------------------------------------------------------------
// iopbc_rsp_if
// response channel: check results
// ---------------------------------------------------------------------------
interface iopbc_rsp_if;
    logic valid;
    logic ready;
    logic gp_fault;
    logic bitmap_used;

    modport source (
        output valid, gp_fault, bitmap_used,
        input  ready
    );
    modport sink (
        input  valid, gp_fault, bitmap_used,
        output ready
    );
endinterface

@@ rtl/io_permission_bitmap_check_top.sv @@
// ---------------------------------------------------------------------------
// io_permission_bitmap_check_top
// x86 i/o permission bitmap check with an 8 KiB bitmap store
// ---------------------------------------------------------------------------
// A load transfer writes one bitmap byte and gives no result. A check has the
// single-port bitmap memory read the byte holding the first port, then the
// following byte, and the verdict is placed in the output register; a new
// transfer can be accepted while that verdict is loaded, as long as the
// consumer keeps up. A result waiting in the output register stalls a new
// transfer only once the next check is done. The bitmap store is not cleared
// at reset; bytes must be loaded before use. Configuration is to be written
// through cfg_we/cfg_index/cfg_data while idle; the block does not enforce it.
module io_permission_bitmap_check_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    iopbc_req_if.sink                            req,
    iopbc_rsp_if.source                          rsp,
    input  logic                                 cfg_we,
    input  logic [iopbc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [iopbc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import iopbc_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign status.in_valid    = req.valid;
    assign status.in_is_check = req.opcode;
    assign status.out_ready   = rsp.ready;

    iopbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .status    (status),
        .cmd       (cmd),
        .in_ready  (req.ready),
        .out_valid (rsp.valid)
    );

    iopbc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .opcode      (req.opcode),
        .port        (req.port),
        .access_len  (req.access_len),
        .map_index   (req.map_index),
        .map_byte    (req.map_byte),
        .gp_fault    (rsp.gp_fault),
        .bitmap_used (rsp.bitmap_used)
    );

endmodule

@@ rtl/iopbc_ctrl.sv @@
// ---------------------------------------------------------------------------
// iopbc_ctrl
// sequencer for loads, the two bitmap reads of a check and the result slot
// ---------------------------------------------------------------------------
`include "io_permission_bitmap_check_top_macros.svh"

module iopbc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  iopbc_pkg::status_t status,
    output iopbc_pkg::cmd_t    cmd,
    output logic              in_ready,
    output logic              out_valid
);
    import iopbc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        slot_free = !out_valid_reg || status.out_ready;
        in_ready  = (state_reg == ST_IDLE) || ((state_reg == ST_RD1) && slot_free);
        accept    = status.in_valid && in_ready;

        cmd.mem_we       = accept && (status.in_is_check == OP_LOAD);
        cmd.addr_from_in = accept;
        cmd.capture      = accept && (status.in_is_check == OP_CHECK);
        cmd.latch_byte0  = (state_reg == ST_RD0);
        cmd.load_out     = (state_reg == ST_RD1) && slot_free;

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_RD0;
                end
            end
            ST_RD0:
            begin
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                if (slot_free)
                begin
                    state_next = cmd.capture ? ST_RD0 : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (status.out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        out_valid = out_valid_reg;
    end

    // a captured check always goes on to read its first byte
    `IOPBC_ASSERT_NEXT(a_capture_reads, clk, rst_n, cmd.capture, state_reg == ST_RD0, "check not read")
    // the second read follows the first without a gap
    `IOPBC_ASSERT_NEXT(a_rd0_to_rd1, clk, rst_n, state_reg == ST_RD0, state_reg == ST_RD1, "read order")
    // a finished check is offered on the next cycle
    `IOPBC_ASSERT_NEXT(a_result_shown, clk, rst_n, cmd.load_out, out_valid_reg, "result lost")

endmodule

@@ rtl/iopbc_datapath.sv @@
// ---------------------------------------------------------------------------
// iopbc_datapath
// configuration registers, bitmap memory and fault evaluation
// ---------------------------------------------------------------------------
module iopbc_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  iopbc_pkg::cmd_t                      cmd,
    input  logic                                 cfg_we,
    input  logic [iopbc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [iopbc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 opcode,
    input  logic [iopbc_pkg::PORT_W-1:0]         port,
    input  logic [iopbc_pkg::LEN_W-1:0]          access_len,
    input  logic [iopbc_pkg::INDEX_W-1:0]        map_index,
    input  logic [iopbc_pkg::BYTE_W-1:0]         map_byte,
    output logic                                 gp_fault,
    output logic                                 bitmap_used
);
    import iopbc_pkg::*;

    logic                  protected_mode_reg;
    logic                  virtual_8086_reg;
    logic [PRIV_W-1:0]     current_privilege_reg;
    logic [PRIV_W-1:0]     io_privilege_reg;
    logic [LIMIT_W-1:0]    bitmap_limit_reg;

    logic [BYTE_W-1:0]     mem [BITMAP_BYTES];
    logic [BYTE_W-1:0]     rdata_reg;
    logic [ADDR_W-1:0]     mem_addr;
    logic                  mem_write;

    logic [PORT_W-1:0]     port_reg;
    logic [LEN_W-1:0]      len_reg;
    logic                  fault0_reg;
    logic                  fault0_next;
    logic                  gp_fault_reg;
    logic                  bitmap_used_reg;

    logic [INDEX_W-1:0]    off;
    logic [BIT_W-1:0]      bitpos;
    logic [LIMIT_W-1:0]    off_ext;
    logic [LIMIT_W-1:0]    off1_ext;
    logic [SPAN_W-1:0]     span;
    logic [BYTE_W-1:0]     mask0;
    logic [BYTE_W-1:0]     mask1;
    logic                  fault1;
    logic                  used;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            protected_mode_reg    <= 1'b0;
            virtual_8086_reg      <= 1'b0;
            current_privilege_reg <= '0;
            io_privilege_reg      <= '0;
            bitmap_limit_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PROTECTED_MODE:    protected_mode_reg    <= cfg_data[0];
                CFG_VIRTUAL_8086:      virtual_8086_reg      <= cfg_data[0];
                CFG_CURRENT_PRIVILEGE: current_privilege_reg <= cfg_data[PRIV_W-1:0];
                CFG_IO_PRIVILEGE:      io_privilege_reg      <= cfg_data[PRIV_W-1:0];
                CFG_BITMAP_LIMIT:      bitmap_limit_reg      <= cfg_data[LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // bitmap byte address: new item or the byte after the captured one
    always_comb
    begin
        off      = port_reg[PORT_W-1:BIT_W];
        bitpos   = port_reg[BIT_W-1:0];
        off_ext  = LIMIT_W'(off);
        off1_ext = off_ext + LIMIT_W'(1);

        if (cmd.addr_from_in)
        begin
            if (opcode == OP_LOAD)
            begin
                mem_addr = ADDR_W'(map_index);
            end
            else
            begin
                mem_addr = ADDR_W'(port[PORT_W-1:BIT_W]);
            end
        end
        else
        begin
            mem_addr = ADDR_W'(off1_ext);
        end

        mem_write = cmd.mem_we && (LIMIT_W'(map_index) < LIMIT_W'(BITMAP_BYTES));
    end

    always_ff @(posedge clk)
    begin
        if (mem_write)
        begin
            mem[mem_addr] <= map_byte;
        end
        rdata_reg <= mem[mem_addr];
    end

    // port masks within the first and the second byte, the fault of each byte and whether the bitmap is used
    always_comb
    begin
        span = SPAN_W'(bitpos) + SPAN_W'(len_reg);
        for (int j = 0; j < BYTE_W; j++)
        begin
            mask0[j] = (BIT_W'(j) >= bitpos) && (SPAN_W'(j) < span);
            mask1[j] = (SPAN_W'(j + BYTE_W) < span);
        end

        fault0_next = (len_reg != '0) &&
                      ((off_ext >= bitmap_limit_reg) ||
                       (off_ext >= LIMIT_W'(BITMAP_BYTES)) ||
                       ((rdata_reg & mask0) != '0));

        fault1 = (span > SPAN_W'(BYTE_W)) &&
                 ((off1_ext >= bitmap_limit_reg) ||
                  (off1_ext >= LIMIT_W'(BITMAP_BYTES)) ||
                  ((rdata_reg & mask1) != '0));

        used = protected_mode_reg &&
               (virtual_8086_reg || (current_privilege_reg > io_privilege_reg));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            port_reg <= port;
            len_reg  <= access_len;
        end
        if (cmd.latch_byte0)
        begin
            fault0_reg <= fault0_next;
        end
        if (cmd.load_out)
        begin
            gp_fault_reg    <= used &&
                               ((bitmap_limit_reg == '0) || fault0_reg || fault1);
            bitmap_used_reg <= used;
        end
    end

    assign gp_fault    = gp_fault_reg;
    assign bitmap_used = bitmap_used_reg;

endmodule

@@ test/tb_io_permission_bitmap_check_top.sv @@
// ---------------------------------------------------------------------------
// tb_io_permission_bitmap_check_top
// self-checking bench for the i/o permission bitmap check. A directed table
// of config writes, loads and checks comes first, then random phases with
// fresh settings. Before a random check every bitmap byte that it may reach
// is loaded, so its verdict never rests on an unwritten byte. A check's verdict
// is taken from the directed table or predicted from a shadow bitmap and shadow
// registers, and is compared field by field with the response channel.
// ---------------------------------------------------------------------------
module tb_io_permission_bitmap_check_top;
    timeunit 1ns;
    timeprecision 1ps;

    import iopbc_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int DRAIN_CYCLES  = 6;
    localparam int HOLD_AT       = 60;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 30;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_LOAD,
        ROW_CHECK
    } row_kind_t;

    typedef struct packed {
        logic gp_fault;
        logic bitmap_used;
    } verdict_t;

    typedef struct {
        row_kind_t               kind;
        logic [CFG_INDEX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0]   reg_data;
        logic [PORT_W-1:0]       port;
        logic [LEN_W-1:0]        len;
        logic [INDEX_W-1:0]      index;
        logic [BYTE_W-1:0]       value;
        bit                      typed;
        verdict_t                verdict;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    iopbc_req_if req_ch ();
    iopbc_rsp_if rsp_ch ();

    io_permission_bitmap_check_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [BYTE_W-1:0]  map_shadow [BITMAP_BYTES];
    bit                 map_written [BITMAP_BYTES];
    logic               cfg_protected;
    logic               cfg_v86;
    logic [PRIV_W-1:0]  cfg_cpl;
    logic [PRIV_W-1:0]  cfg_iopl;
    logic [LIMIT_W-1:0] cfg_limit;

    verdict_t  pending_verdicts [$];
    stim_row_t directed_rows [$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  tx_items       = 0;
    bit  tx_burst       = 0;
    int  results_seen   = 0;
    bit  rx_burst       = 0;
    bit  rx_held        = 0;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic verdict_t predict_verdict(input logic [PORT_W-1:0] first_port,
                                                 input logic [LEN_W-1:0] count);
        verdict_t v;
        int       offset;
        int       bit_pos;
        int       remaining;
        v.bitmap_used = cfg_protected && (cfg_v86 || cfg_cpl > cfg_iopl);
        v.gp_fault    = 1'b0;
        if (v.bitmap_used)
        begin
            if (cfg_limit == 0)
            begin
                v.gp_fault = 1'b1;
            end
            else
            begin
                offset    = first_port >> 3;
                bit_pos   = first_port & 7;
                remaining = count;
                while (remaining > 0 && !v.gp_fault)
                begin
                    if (offset >= cfg_limit || offset >= BITMAP_BYTES)
                    begin
                        v.gp_fault = 1'b1;
                    end
                    else
                    begin
                        while (remaining > 0 && bit_pos < 8)
                        begin
                            if (map_shadow[offset][bit_pos])
                                v.gp_fault = 1'b1;
                            remaining--;
                            bit_pos++;
                        end
                    end
                    offset++;
                    bit_pos = 0;
                end
            end
        end
        return v;
    endfunction

    function automatic void add_cfg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        stim_row_t r;
        r           = '{kind: ROW_CFG, default: '0};
        r.reg_index = idx;
        r.reg_data  = data;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_load(input logic [INDEX_W-1:0] idx,
                                     input logic [BYTE_W-1:0] value);
        stim_row_t r;
        r       = '{kind: ROW_LOAD, default: '0};
        r.index = idx;
        r.value = value;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_check(input logic [PORT_W-1:0] port,
                                      input logic [LEN_W-1:0] len,
                                      input bit typed,
                                      input logic fault,
                                      input logic used);
        stim_row_t r;
        r                     = '{kind: ROW_CHECK, default: '0};
        r.port                = port;
        r.len                 = len;
        r.typed               = typed;
        r.verdict.gp_fault    = fault;
        r.verdict.bitmap_used = used;
        directed_rows.push_back(r);
    endfunction

    // called at a falling edge, returns at a falling edge with the block idle
    task automatic settle();
        req_ch.valid = 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        case (idx)
            CFG_PROTECTED_MODE:    cfg_protected = data[0];
            CFG_VIRTUAL_8086:      cfg_v86       = data[0];
            CFG_CURRENT_PRIVILEGE: cfg_cpl       = data[PRIV_W-1:0];
            CFG_IO_PRIVILEGE:      cfg_iopl      = data[PRIV_W-1:0];
            CFG_BITMAP_LIMIT:      cfg_limit     = data[LIMIT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_item(input logic op,
                             input logic [PORT_W-1:0] port,
                             input logic [LEN_W-1:0] len,
                             input logic [INDEX_W-1:0] index,
                             input logic [BYTE_W-1:0] value,
                             input bit typed,
                             input verdict_t typed_verdict);
        int gap;
        if (tx_items % 64 == 0)
            tx_burst = ($urandom_range(0, 3) == 0);
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.opcode     = op;
        req_ch.port       = port;
        req_ch.access_len = len;
        req_ch.map_index  = index;
        req_ch.map_byte   = value;
        req_ch.valid      = 1'b1;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        if (op == OP_LOAD)
        begin
            map_shadow[index]  = value;
            map_written[index] = 1'b1;
        end
        else
            pending_verdicts.push_back(typed ? typed_verdict : predict_verdict(port, len));
        tx_items++;
        @(negedge clk);
    endtask

    // load every unwritten byte that a check may reach
    task automatic prime_bytes(input logic [PORT_W-1:0] first_port,
                               input logic [LEN_W-1:0] count);
        int                first;
        int                last;
        logic [BYTE_W-1:0] fill;
        if (count != '0)
        begin
            first = first_port >> 3;
            last  = (int'(first_port) + int'(count) - 1) >> 3;
            for (int b = first; b <= last; b++)
            begin
                if (b < BITMAP_BYTES && !map_written[b])
                begin
                    fill = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h00;
                    send_item(OP_LOAD, 16'($urandom), 3'($urandom), INDEX_W'(b), fill,
                              0, '0);
                end
            end
        end
    endtask

    // response side
    initial
    begin
        verdict_t want;
        int       gap;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (results_seen % 32 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            if (results_seen == HOLD_AT && !rx_held)
            begin
                rsp_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                rx_held = 1;
            end
            gap = rx_burst ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (rsp_ch.valid !== 1'b1);
            if (pending_verdicts.size() == 0)
            begin
                $error("unexpected result: gp_fault=%0b bitmap_used=%0b",
                       rsp_ch.gp_fault, rsp_ch.bitmap_used);
                mismatch_count++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (rsp_ch.gp_fault !== want.gp_fault)
                begin
                    $error("gp_fault: expected %0b, got %0b", want.gp_fault, rsp_ch.gp_fault);
                    mismatch_count++;
                end
                if (rsp_ch.bitmap_used !== want.bitmap_used)
                begin
                    $error("bitmap_used: expected %0b, got %0b",
                           want.bitmap_used, rsp_ch.bitmap_used);
                    mismatch_count++;
                end
            end
            results_seen++;
            @(negedge clk);
        end
    end

    // request side and run control
    initial
    begin
        stim_row_t           r;
        int                  pick;
        logic [PORT_W-1:0]   hot_base;
        logic [PORT_W-1:0]   port;
        logic [LEN_W-1:0]    len;
        logic [INDEX_W-1:0]  index;
        logic [BYTE_W-1:0]   value;
        logic [CFG_DATA_W-1:0] limit;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        req_ch.valid      = 1'b0;
        req_ch.opcode     = OP_LOAD;
        req_ch.port       = '0;
        req_ch.access_len = '0;
        req_ch.map_index  = '0;
        req_ch.map_byte   = '0;
        cfg_protected     = 1'b0;
        cfg_v86           = 1'b0;
        cfg_cpl           = '0;
        cfg_iopl          = '0;
        cfg_limit         = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        add_check(16'd0, 3'd1, 1, 1'b0, 1'b0);
        add_check(16'hFFFF, 3'd4, 1, 1'b0, 1'b0);
        add_cfg(CFG_PROTECTED_MODE, 14'd1);
        add_check(16'd100, 3'd2, 1, 1'b0, 1'b0);
        add_cfg(CFG_CURRENT_PRIVILEGE, 14'd3);
        add_check(16'd0, 3'd1, 1, 1'b1, 1'b1);
        add_check(16'd8, 3'd0, 1, 1'b1, 1'b1);
        add_cfg(CFG_BITMAP_LIMIT, 14'd8192);
        add_load(13'd0, 8'h01);
        add_check(16'd0, 3'd1, 0, 1'b0, 1'b0);
        add_check(16'd1, 3'd4, 0, 1'b0, 1'b0);
        add_load(13'd8191, 8'h80);
        add_check(16'hFFFF, 3'd1, 0, 1'b0, 1'b0);
        add_check(16'hFFF8, 3'd7, 0, 1'b0, 1'b0);
        add_load(13'd8191, 8'h00);
        add_check(16'hFFFF, 3'd2, 1, 1'b1, 1'b1);
        add_check(16'd8, 3'd0, 1, 1'b0, 1'b1);
        add_cfg(CFG_BITMAP_LIMIT, 14'd1);
        add_check(16'd8, 3'd1, 1, 1'b1, 1'b1);
        add_check(16'd6, 3'd2, 0, 1'b0, 1'b0);
        add_check(16'd7, 3'd2, 1, 1'b1, 1'b1);
        add_cfg(CFG_VIRTUAL_8086, 14'd1);
        add_cfg(CFG_CURRENT_PRIVILEGE, 14'd0);
        add_cfg(CFG_IO_PRIVILEGE, 14'd3);
        add_load(13'd0, 8'h00);
        add_check(16'd0, 3'd5, 0, 1'b0, 1'b0);
        add_check(16'd3, 3'd7, 1, 1'b1, 1'b1);
        add_cfg(CFG_PROTECTED_MODE, 14'd0);
        add_check(16'd7, 3'd2, 1, 1'b0, 1'b0);
        add_cfg(CFG_PROTECTED_MODE, 14'd1);
        add_cfg(CFG_VIRTUAL_8086, 14'd0);
        add_cfg(CFG_CURRENT_PRIVILEGE, 14'd3);
        add_check(16'd0, 3'd1, 1, 1'b0, 1'b0);
        add_cfg(CFG_IO_PRIVILEGE, 14'd2);
        add_check(16'd0, 3'd4, 0, 1'b0, 1'b0);

        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            case (r.kind)
                ROW_CFG:
                begin
                    settle();
                    write_reg(r.reg_index, r.reg_data);
                end
                ROW_LOAD:
                    send_item(OP_LOAD, 16'($urandom), 3'($urandom), r.index, r.value, 0, '0);
                default:
                    send_item(OP_CHECK, r.port, r.len, 13'($urandom), 8'($urandom),
                              r.typed, r.verdict);
            endcase
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            hot_base = 16'($urandom);
            case (phase % 6)
                0:       limit = 14'd8192;
                1:       limit = 14'd0;
                2:       limit = 14'd1;
                3:       limit = 14'd8191;
                4:       limit = 14'($urandom_range(0, 8192));
                default: limit = 14'((hot_base >> 3) + $urandom_range(0, 2));
            endcase
            settle();
            write_reg(CFG_PROTECTED_MODE, 14'($urandom_range(0, 4) != 0));
            write_reg(CFG_VIRTUAL_8086, 14'($urandom_range(0, 1)));
            write_reg(CFG_CURRENT_PRIVILEGE, 14'($urandom_range(0, 3)));
            write_reg(CFG_IO_PRIVILEGE, 14'($urandom_range(0, 3)));
            write_reg(CFG_BITMAP_LIMIT, limit);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                begin
                    if ($urandom_range(0, 1) == 0)
                        index = 13'($urandom);
                    else
                        index = 13'((hot_base >> 3) + $urandom_range(0, 4));
                    case ($urandom_range(0, 2))
                        0:       value = 8'h00;
                        1:       value = 8'(1 << $urandom_range(0, 7));
                        default: value = 8'($urandom);
                    endcase
                    send_item(OP_LOAD, 16'($urandom), 3'($urandom), index, value, 0, '0);
                end
                else
                begin
                    if (pick < 85)
                    begin
                        len  = 3'(1 << $urandom_range(0, 2));
                        port = ($urandom_range(0, 1) == 0) ?
                               16'(hot_base + $urandom_range(0, 31)) : 16'($urandom);
                    end
                    else
                    begin
                        len  = 3'($urandom_range(0, 7));
                        port = 16'($urandom);
                    end
                    prime_bytes(port, len);
                    send_item(OP_CHECK, port, len, 13'($urandom), 8'($urandom), 0, '0);
                end
            end
        end

        settle();
        repeat (20) @(negedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ io_permission_bitmap_check_top.f @@
+incdir+rtl
rtl/iopbc_pkg.sv
rtl/iopbc_req_if.sv
rtl/iopbc_rsp_if.sv
rtl/iopbc_ctrl.sv
rtl/iopbc_datapath.sv
rtl/io_permission_bitmap_check_top.sv
test/tb_io_permission_bitmap_check_top.sv
